// File: src/pcx_rle_pixel_decoder_defines.svh
// Assertion macros used by the decoder checker.
`ifndef PCX_RLE_PIXEL_DECODER_DEFINES_SVH
`define PCX_RLE_PIXEL_DECODER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PCXD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcxd assertion failed");

// Antecedent implies consequent in the next cycle.
`define PCXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcxd assertion failed");

`endif

// File: src/pcxd_pkg.sv
// Shared types and constants of the PCX run-length pixel decoder.
`timescale 1ns / 1ps
package pcxd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int BPL_MAX    = 2048;

    localparam logic [7:0] RUN_MARK = 8'hC0;

    // item functions
    localparam logic [1:0] FUNC_PAL   = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_CONT  = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    // pixel modes
    localparam logic [1:0] MODE_1BIT = 2'd0;
    localparam logic [1:0] MODE_4PL  = 2'd1;
    localparam logic [1:0] MODE_8BIT = 2'd2;
    localparam logic [1:0] MODE_24   = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BPL    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // pipeline operations
    localparam logic [2:0] OP_STAT   = 3'd0;
    localparam logic [2:0] OP_PAL_WR = 3'd1;
    localparam logic [2:0] OP_BIT    = 3'd2;
    localparam logic [2:0] OP_BITPL  = 3'd3;
    localparam logic [2:0] OP_IDX    = 3'd4;
    localparam logic [2:0] OP_RGB    = 3'd5;

    // one step handed from the sequencer to the pixel pipeline
    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] col;
        logic        bitv;
        logic [7:0]  d;
        logic [1:0]  plane;
        logic [11:0] row;
        logic        rp;
        logic        dn;
        logic        last;
        logic [7:0]  pidx;
        logic [23:0] pcol;
    } step_t;

    // one decoded item waiting in the sequencer
    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] base;
        logic [3:0]  nsteps;
        logic [7:0]  d;
        logic [1:0]  plane;
        logic [11:0] row;
        logic        rp;
        logic        dn;
        logic [7:0]  pidx;
        logic [23:0] pcol;
    } job_t;

    // pipeline stage after the line store read
    typedef struct packed {
        logic        emit;
        logic        pix;
        logic        use_pal;
        logic [10:0] col;
        logic [11:0] row;
        logic [23:0] rgb;
        logic        rp;
        logic        dn;
        logic        last;
    } pix_t;

endpackage

// File: src/pcxd_ctrl.sv
// Run-length state, scan position and per-item step sequencer.
`timescale 1ns / 1ps
module pcxd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        palette_index,
    input  logic [23:0]       palette_color,
    input  logic              adv,
    output logic              step_valid,
    output pcxd_pkg::step_t   step
);

    logic [1:0]  mode_reg;
    logic [11:0] bpl_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    logic [5:0]  run_left_reg, run_left_next;
    logic [7:0]  run_byte_reg, run_byte_next;
    logic        await_reg, await_next;
    logic [10:0] bip_reg, bip_next;
    logic [1:0]  plane_reg, plane_next;
    logic [11:0] scan_reg, scan_next;
    logic        fin_reg, fin_next;

    logic             s1_v_reg;
    pcxd_pkg::job_t   job_reg, job_next;
    logic [2:0]       j_reg;

    logic [11:0] eff_bpl;
    logic [11:0] eff_w;
    logic [12:0] eff_h;
    logic [2:0]  planes;
    logic        s1_last;
    logic        accept;
    logic [13:0] col_sum;

    // clamped register values
    always_comb
    begin
        eff_bpl = (bpl_reg == 12'd0) ? 12'd1 :
                  (bpl_reg > 12'(pcxd_pkg::BPL_MAX)) ? 12'(pcxd_pkg::BPL_MAX) : bpl_reg;
        eff_w   = (width_reg > 12'(pcxd_pkg::MAX_WIDTH)) ? 12'(pcxd_pkg::MAX_WIDTH)
                                                         : width_reg;
        eff_h   = (height_reg == 13'd0) ? 13'd1 :
                  (height_reg > 13'(pcxd_pkg::MAX_HEIGHT)) ? 13'(pcxd_pkg::MAX_HEIGHT)
                                                           : height_reg;
        case (mode_reg)
            pcxd_pkg::MODE_4PL: planes = 3'd4;
            pcxd_pkg::MODE_24:  planes = 3'd3;
            default:            planes = 3'd1;
        endcase
    end

    assign s1_last  = ({1'b0, j_reg} + 4'd1) == job_reg.nsteps;
    assign in_ready = !s1_v_reg || (adv && s1_last);
    assign accept   = in_valid && in_ready;

    // next state of one item
    always_comb
    begin
        logic        dec;
        logic [13:0] col0;
        logic [13:0] rem;
        logic [11:0] bip1;
        logic [2:0]  pl1;
        logic [12:0] sl1;
        logic [12:0] rowx;

        run_left_next = run_left_reg;
        run_byte_next = run_byte_reg;
        await_next    = await_reg;
        bip_next      = bip_reg;
        plane_next    = plane_reg;
        scan_next     = scan_reg;
        fin_next      = fin_reg;
        dec           = 1'b0;
        col0          = {bip_reg, 3'b000};
        rem           = 14'(eff_w) - col0;
        bip1          = {1'b0, bip_reg} + 12'd1;
        pl1           = {1'b0, plane_reg} + 3'd1;
        sl1           = {1'b0, scan_reg} + 13'd1;
        rowx          = eff_h - 13'd1 - {1'b0, scan_reg};

        job_next        = '0;
        job_next.op     = pcxd_pkg::OP_STAT;
        job_next.nsteps = 4'd1;
        job_next.pidx   = palette_index;
        job_next.pcol   = palette_color;

        case (func)
            pcxd_pkg::FUNC_PAL:
            begin
                job_next.op = pcxd_pkg::OP_PAL_WR;
            end
            pcxd_pkg::FUNC_START:
            begin
                run_left_next = '0;
                run_byte_next = '0;
                await_next    = 1'b0;
                bip_next      = '0;
                plane_next    = '0;
                scan_next     = '0;
                fin_next      = 1'b0;
            end
            pcxd_pkg::FUNC_BYTE:
            begin
                if (!fin_reg && ({1'b0, scan_reg} >= eff_h))
                begin
                    fin_next      = 1'b1;
                    run_left_next = '0;
                    await_next    = 1'b0;
                end
                else if (!fin_reg)
                begin
                    if (await_reg)
                    begin
                        run_byte_next = data_byte;
                        await_next    = 1'b0;
                        if (run_left_reg != 6'd0)
                        begin
                            run_left_next = run_left_reg - 6'd1;
                            dec           = 1'b1;
                        end
                    end
                    else if (run_left_reg != 6'd0)
                    begin
                        // byte ignored while a run is pending
                    end
                    else if (data_byte >= pcxd_pkg::RUN_MARK)
                    begin
                        run_left_next = data_byte[5:0];
                        await_next    = 1'b1;
                    end
                    else
                    begin
                        run_byte_next = data_byte;
                        dec           = 1'b1;
                    end
                end
            end
            default:
            begin
                if (!fin_reg && ({1'b0, scan_reg} >= eff_h))
                begin
                    fin_next      = 1'b1;
                    run_left_next = '0;
                    await_next    = 1'b0;
                end
                else if (!fin_reg && !await_reg && (run_left_reg != 6'd0))
                begin
                    run_left_next = run_left_reg - 6'd1;
                    dec           = 1'b1;
                end
            end
        endcase

        if (dec)
        begin
            job_next.d     = run_byte_next;
            job_next.plane = plane_reg;
            job_next.row   = rowx[11:0];
            job_next.base  = bip_reg;
            case (mode_reg)
                pcxd_pkg::MODE_1BIT, pcxd_pkg::MODE_4PL:
                begin
                    if (col0 < 14'(eff_w))
                    begin
                        job_next.op     = (mode_reg == pcxd_pkg::MODE_1BIT) ?
                                          pcxd_pkg::OP_BIT : pcxd_pkg::OP_BITPL;
                        job_next.nsteps = (rem >= 14'd8) ? 4'd8 : rem[3:0];
                    end
                end
                pcxd_pkg::MODE_8BIT:
                begin
                    if ({1'b0, bip_reg} < eff_w)
                    begin
                        job_next.op = pcxd_pkg::OP_IDX;
                    end
                end
                default:
                begin
                    if (({1'b0, bip_reg} < eff_w) && (plane_reg != 2'd3))
                    begin
                        job_next.op = pcxd_pkg::OP_RGB;
                    end
                end
            endcase

            // advance the scan position
            if (bip1 >= eff_bpl)
            begin
                bip_next = '0;
                if (pl1 >= planes)
                begin
                    plane_next = '0;
                    scan_next  = sl1[11:0];
                    if (sl1 >= eff_h)
                    begin
                        fin_next      = 1'b1;
                        run_left_next = '0;
                        await_next    = 1'b0;
                    end
                end
                else
                begin
                    plane_next = pl1[1:0];
                end
            end
            else
            begin
                bip_next = bip1[10:0];
            end
        end

        job_next.rp = !fin_next && !await_next && (run_left_next != 6'd0);
        job_next.dn = fin_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pcxd_pkg::MODE_8BIT;
            bpl_reg    <= 12'd1;
            width_reg  <= 12'd1;
            height_reg <= 13'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pcxd_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                pcxd_pkg::CFG_BPL:    bpl_reg    <= cfg_data[11:0];
                pcxd_pkg::CFG_WIDTH:  width_reg  <= cfg_data[11:0];
                default:              height_reg <= cfg_data;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_left_reg <= '0;
            run_byte_reg <= '0;
            await_reg    <= 1'b0;
            bip_reg      <= '0;
            plane_reg    <= '0;
            scan_reg     <= '0;
            fin_reg      <= 1'b0;
        end
        else if (accept)
        begin
            run_left_reg <= run_left_next;
            run_byte_reg <= run_byte_next;
            await_reg    <= await_next;
            bip_reg      <= bip_next;
            plane_reg    <= plane_next;
            scan_reg     <= scan_next;
            fin_reg      <= fin_next;
        end
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            j_reg    <= '0;
        end
        else if (accept)
        begin
            s1_v_reg <= 1'b1;
            j_reg    <= '0;
        end
        else if (adv && s1_v_reg)
        begin
            if (s1_last)
            begin
                s1_v_reg <= 1'b0;
            end
            else
            begin
                j_reg <= j_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    // current step
    assign col_sum    = {job_reg.base, 3'b000} + {11'd0, j_reg};
    assign step_valid = s1_v_reg;

    always_comb
    begin
        step       = '0;
        step.op    = job_reg.op;
        step.col   = ((job_reg.op == pcxd_pkg::OP_BIT) || (job_reg.op == pcxd_pkg::OP_BITPL))
                     ? col_sum[10:0] : job_reg.base;
        step.bitv  = job_reg.d[3'd7 - j_reg];
        step.d     = job_reg.d;
        step.plane = job_reg.plane;
        step.row   = job_reg.row;
        step.rp    = job_reg.rp;
        step.dn    = job_reg.dn;
        step.last  = s1_last;
        step.pidx  = job_reg.pidx;
        step.pcol  = job_reg.pcol;
    end

endmodule

// File: src/pcxd_pixel_pipe.sv
// Line store and palette read-modify-write pipeline with the output register.
`timescale 1ns / 1ps
module pcxd_pixel_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_valid,
    input  pcxd_pkg::step_t   step,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pixel_valid,
    output logic [10:0]       column,
    output logic [11:0]       row,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic              run_pending,
    output logic              image_done,
    output logic              last
);

    logic [15:0] line_mem [pcxd_pkg::MAX_WIDTH];
    logic [23:0] pal_mem  [256];

    logic             p2_v_reg;
    pcxd_pkg::step_t  p2_reg;
    logic [15:0]      ls_rd_reg;
    logic             fwd_v_reg;
    logic [10:0]      fwd_a_reg;
    logic [15:0]      fwd_d_reg;

    logic             p3_v_reg;
    pcxd_pkg::pix_t   p3_reg, p3_next;
    logic [23:0]      pal_rd_reg;

    logic             out_valid_reg;
    pcxd_pkg::pix_t   out_reg;
    logic [23:0]      out_rgb_reg;

    logic [15:0] lsv;
    logic [3:0]  idx4;
    logic        wr_en;
    logic [15:0] wr_data;
    logic        pal_wr;
    logic [7:0]  pal_addr;

    assign adv = !out_valid_reg || out_ready;

    // modify stage: forwarded line entry, write-back and palette address
    always_comb
    begin
        lsv  = (fwd_v_reg && (fwd_a_reg == p2_reg.col)) ? fwd_d_reg : ls_rd_reg;
        idx4 = (p2_reg.plane == 2'd0) ? {3'b000, p2_reg.bitv}
                                      : (lsv[3:0] | ({3'b000, p2_reg.bitv} << p2_reg.plane));
        wr_en    = 1'b0;
        wr_data  = '0;
        pal_wr   = 1'b0;
        pal_addr = p2_reg.d;
        p3_next  = '0;
        p3_next.emit = 1'b1;
        p3_next.rp   = p2_reg.rp;
        p3_next.dn   = p2_reg.dn;
        p3_next.last = p2_reg.last;

        case (p2_reg.op)
            pcxd_pkg::OP_PAL_WR:
            begin
                pal_wr = p2_v_reg;
            end
            pcxd_pkg::OP_BIT:
            begin
                pal_addr        = {7'd0, p2_reg.bitv};
                p3_next.pix     = 1'b1;
                p3_next.use_pal = 1'b1;
            end
            pcxd_pkg::OP_BITPL:
            begin
                pal_addr = {4'd0, idx4};
                if (p2_reg.plane == 2'd3)
                begin
                    p3_next.pix     = 1'b1;
                    p3_next.use_pal = 1'b1;
                end
                else
                begin
                    wr_en        = p2_v_reg;
                    wr_data      = {12'd0, idx4};
                    p3_next.emit = p2_reg.last;
                end
            end
            pcxd_pkg::OP_IDX:
            begin
                p3_next.pix     = 1'b1;
                p3_next.use_pal = 1'b1;
            end
            pcxd_pkg::OP_RGB:
            begin
                case (p2_reg.plane)
                    2'd0:
                    begin
                        wr_en   = p2_v_reg;
                        wr_data = {p2_reg.d, 8'd0};
                    end
                    2'd1:
                    begin
                        wr_en   = p2_v_reg;
                        wr_data = {lsv[15:8], p2_reg.d};
                    end
                    default:
                    begin
                        p3_next.pix = 1'b1;
                        p3_next.rgb = {lsv, p2_reg.d};
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (p3_next.pix)
        begin
            p3_next.col = p2_reg.col;
            p3_next.row = p2_reg.row;
        end
    end

    // line store: read for the next step, write-back for this one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                line_mem[p2_reg.col] <= wr_data;
            end
            ls_rd_reg <= line_mem[step.col];
        end
    end

    // palette
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pal_wr)
            begin
                pal_mem[p2_reg.pidx] <= p2_reg.pcol;
            end
            pal_rd_reg <= pal_mem[pal_addr];
        end
    end

    // stage valids and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            fwd_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_v_reg      <= step_valid;
            p3_v_reg      <= p2_v_reg;
            fwd_v_reg     <= wr_en;
            out_valid_reg <= p3_v_reg && p3_reg.emit;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg      <= step;
            p3_reg      <= p3_next;
            fwd_a_reg   <= p2_reg.col;
            fwd_d_reg   <= wr_data;
            out_reg     <= p3_reg;
            out_rgb_reg <= p3_reg.use_pal ? pal_rd_reg : p3_reg.rgb;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = out_reg.pix;
    assign column      = out_reg.col;
    assign row         = out_reg.row;
    assign red         = out_rgb_reg[23:16];
    assign green       = out_rgb_reg[15:8];
    assign blue        = out_rgb_reg[7:0];
    assign run_pending = out_reg.rp;
    assign image_done  = out_reg.dn;
    assign last        = out_reg.last;

endmodule

// File: src/pcx_rle_pixel_decoder.sv
// Top level of the PCX run-length pixel decoder.
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_ready    func, data_byte, palette_index, palette_color
//   out      out_valid/out_ready  pixel_valid, column, row, red, green, blue,
//                                 run_pending, image_done, last
//
// 8-bit and 24-bit modes take one input beat per cycle while the output is
// not stalled; a 1-bit or 4-plane byte takes one step per column kept (up
// to 8), as palette and line store step one pixel a cycle. A beat passes the
// job, p2, p3 and output registers in order. Reset clears control state only;
// palette and line store need no clearing pass. An output stall freezes the whole pipe.
`timescale 1ns / 1ps
module pcx_rle_pixel_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  palette_index,
    input  logic [23:0] palette_color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        pixel_valid,
    output logic [10:0] column,
    output logic [11:0] row,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        run_pending,
    output logic        image_done,
    output logic        last
);

    logic             adv;
    logic             step_valid;
    pcxd_pkg::step_t  step;

    assign cfg_ready = 1'b1;

    pcxd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .data_byte     (data_byte),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .adv           (adv),
        .step_valid    (step_valid),
        .step          (step)
    );

    pcxd_pixel_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid),
        .step        (step),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_valid (pixel_valid),
        .column      (column),
        .row         (row),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .run_pending (run_pending),
        .image_done  (image_done),
        .last        (last)
    );

endmodule

// File: src/pcxd_checker.sv
// Port-level checker of the decoder and its bind.
`timescale 1ns / 1ps
`include "pcx_rle_pixel_decoder_defines.svh"
module pcxd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        pixel_valid,
    input logic [10:0] column,
    input logic [11:0] row,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        run_pending,
    input logic        image_done,
    input logic        last
);

    // a stalled result beat holds
    `PCXD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(column) && $stable(row) && $stable(red) && $stable(last))
    // status beats carry no position
    `PCXD_ASSERT_IMPL(a_stat_pos, out_valid && !pixel_valid, column == 11'd0 && row == 12'd0)
    // status beats carry no color
    `PCXD_ASSERT_IMPL(a_stat_rgb, out_valid && !pixel_valid, red == 8'd0 && green == 8'd0 && blue == 8'd0)
    // a finished image has no pending run
    `PCXD_ASSERT_IMPL(a_done_run, out_valid && image_done, !run_pending)

endmodule

bind pcx_rle_pixel_decoder pcxd_checker u_pcxd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_valid (pixel_valid),
    .column      (column),
    .row         (row),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .run_pending (run_pending),
    .image_done  (image_done),
    .last        (last)
);
